// File: sv/pmp_pkg.sv
// Package for the parabolic motion profile block: field widths, register map and
// reset values shared by the interfaces, the pipeline core and the top level.
// No dependencies.
package pmp_pkg;

  // Default datapath sizes.
  localparam int PMP_TIME_WIDTH    = 24;
  localparam int PMP_FRACTION_BITS = 16;

  // Field and register widths.
  localparam int PMP_POS_W    = 32;
  localparam int PMP_CFG_TW   = 24;
  localparam int PMP_DEAD_W   = 17;
  localparam int PMP_ADDR_W   = 4;
  localparam int PMP_DATA_W   = 32;
  localparam int PMP_REG_IDXW = 2;

  // Register indexes (byte address is four times the index).
  localparam logic [PMP_REG_IDXW-1:0] REG_TICK   = 2'd0;
  localparam logic [PMP_REG_IDXW-1:0] REG_PERIOD = 2'd1;
  localparam logic [PMP_REG_IDXW-1:0] REG_DEAD   = 2'd2;

  // Register reset values.
  localparam logic [PMP_CFG_TW-1:0] PMP_TICK_RESET   = 24'd10000;
  localparam logic [PMP_CFG_TW-1:0] PMP_PERIOD_RESET = 24'd1000000;
  localparam logic [PMP_DEAD_W-1:0] PMP_DEAD_RESET   = 17'd0;
  localparam logic [PMP_DEAD_W-1:0] PMP_DEAD_ONE     = 17'd65536;

  // Saturation limits of the position output.
  localparam logic [PMP_POS_W-1:0] PMP_POS_MAX = 32'h7fff_ffff;
  localparam logic [PMP_POS_W-1:0] PMP_POS_MIN = 32'h8000_0000;

endpackage

// File: sv/pmp_in_if.sv
// Input channel of the motion profile block: one time sample with its endpoints.
// Depends on pmp_pkg.
interface pmp_in_if import pmp_pkg::*; #(
  parameter int TIME_WIDTH = PMP_TIME_WIDTH
);
  logic                        valid;
  logic                        ready;
  logic [TIME_WIDTH-1:0]       elapsed;
  logic signed [PMP_POS_W-1:0] start_position;
  logic signed [PMP_POS_W-1:0] end_position;

  modport source (output valid, elapsed, start_position, end_position, input ready);
  modport sink   (input valid, elapsed, start_position, end_position, output ready);
endinterface

// File: sv/pmp_out_if.sv
// Result channel of the motion profile block: one interpolated position per word.
// Depends on pmp_pkg.
interface pmp_out_if import pmp_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic signed [PMP_POS_W-1:0] position;
  logic                        saturated;

  modport source (output valid, position, saturated, input ready);
  modport sink   (input valid, position, saturated, output ready);
endinterface

// File: sv/pmp_core.sv
// Pipelined datapath of the motion profile: normalized time by a one-bit-per-stage
// divider, parabola, scaling and saturation. Depends on pmp_pkg, pmp_in_if, pmp_out_if.
module pmp_core import pmp_pkg::*; #(
  parameter int TIME_WIDTH    = PMP_TIME_WIDTH,
  parameter int FRACTION_BITS = PMP_FRACTION_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [TIME_WIDTH-1:0] cfg_period,
  input  logic [TIME_WIDTH-1:0] cfg_tick,
  input  logic [PMP_DEAD_W-1:0] cfg_dead,
  pmp_in_if.sink                in_ch,
  pmp_out_if.source             out_ch
);

  localparam int TW  = TIME_WIDTH;
  localparam int FB  = FRACTION_BITS;
  localparam int DW  = TW + 17;       // dead time, 2^17 per microsecond
  localparam int WW  = TW + 19;       // signed time arithmetic
  localparam int RW  = TW + 18;       // divider remainder
  localparam int FW  = FB + 1;        // fraction, closed interval [0, one]
  localparam int SQW = 2 * FW;
  localparam int YW  = FB + 4;        // signed profile value
  localparam int DFW = PMP_POS_W + 1; // endpoint difference
  localparam int PW  = DFW + YW;      // scaled offset

  localparam logic [1:0] FSEL_DIV  = 2'd0;
  localparam logic [1:0] FSEL_ZERO = 2'd1;
  localparam logic [1:0] FSEL_ONE  = 2'd2;

  localparam logic [FW-1:0] F_ONE = {1'b1, {FB{1'b0}}};
  localparam logic signed [YW-1:0] Y_ONE = $signed({3'b000, F_ONE});

  // Derived timing values after reset.
  localparam logic [TW-1:0] PER_RST = TW'(PMP_PERIOD_RESET);
  localparam logic [TW-1:0] TK_RST  = TW'(PMP_TICK_RESET);
  localparam logic [PMP_DEAD_W-1:0] DF_RST =
    (PMP_DEAD_RESET > PMP_DEAD_ONE) ? PMP_DEAD_ONE : PMP_DEAD_RESET;
  localparam logic [DW-1:0] D_RST = DW'(PER_RST) * DW'(DF_RST);
  localparam logic signed [WW-1:0] P_RST  = $signed({2'b00, PER_RST, 17'd0});
  localparam logic signed [WW-1:0] H_RST  = $signed({3'b000, TK_RST, 16'd0});
  localparam logic signed [WW-1:0] DW_RST = $signed({2'b00, D_RST});
  localparam logic signed [WW-1:0] SPAN_RST = P_RST - DW_RST - DW_RST;
  localparam logic signed [WW-1:0] DH_RST   = DW_RST + H_RST;
  localparam logic signed [WW-1:0] PDH_RST  = P_RST - DW_RST - H_RST;

  typedef struct packed {
    logic [RW-1:0]               rem;
    logic [FB-1:0]               quo;
    logic [1:0]                  fsel;
    logic                        lo;
    logic                        hi;
    logic                        first;
    logic signed [PMP_POS_W-1:0] st;
    logic signed [PMP_POS_W-1:0] en;
  } div_stage_t;

  // ---------------------------------------------------------------------------
  // Timing constants from the registers, held in registers of their own.
  // ---------------------------------------------------------------------------
  logic [PMP_DEAD_W-1:0]  df_clamp;
  logic [DW-1:0]          d_cfg_r, d_cfg_nxt;
  logic signed [WW-1:0]   p_w, h_w, d_w;
  logic signed [WW-1:0]   span_cfg_r, dh_cfg_r, pdh_cfg_r;
  logic [RW-1:0]          span_u;

  assign df_clamp  = (cfg_dead > PMP_DEAD_ONE) ? PMP_DEAD_ONE : cfg_dead;
  assign d_cfg_nxt = DW'(cfg_period) * DW'(df_clamp);
  assign p_w       = $signed({2'b00, cfg_period, 17'd0});
  assign h_w       = $signed({3'b000, cfg_tick, 16'd0});
  assign d_w       = $signed({2'b00, d_cfg_r});
  assign span_u    = span_cfg_r[RW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_cfg_r    <= D_RST;
      span_cfg_r <= SPAN_RST;
      dh_cfg_r   <= DH_RST;
      pdh_cfg_r  <= PDH_RST;
    end else begin
      d_cfg_r    <= d_cfg_nxt;
      span_cfg_r <= p_w - d_w - d_w;
      dh_cfg_r   <= d_w + h_w;
      pdh_cfg_r  <= p_w - d_w - h_w;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage advance chain: a stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------------
  logic          v1_r, v2_r, vf_r, vy_r, vm_r, out_valid_r;
  logic [FB:0]   dv_r;
  logic [FB:0]   dadv;
  logic          adv1, adv2, advf, advy, advm, advo;

  assign advo = !out_valid_r || out_ch.ready;
  assign advm = !vm_r || advo;
  assign advy = !vy_r || advm;
  assign advf = !vf_r || advy;
  assign dadv[FB] = !dv_r[FB] || advf;
  for (genvar k = 0; k < FB; k++) begin : g_adv
    assign dadv[k] = !dv_r[k] || dadv[k+1];
  end
  assign adv2 = !v2_r || dadv[0];
  assign adv1 = !v1_r || adv2;
  assign in_ch.ready = adv1;

  // ---------------------------------------------------------------------------
  // Stage 1: capture the input word.
  // ---------------------------------------------------------------------------
  logic [TW-1:0]               el1_r;
  logic signed [PMP_POS_W-1:0] st1_r, en1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      el1_r <= in_ch.elapsed;
      st1_r <= in_ch.start_position;
      en1_r <= in_ch.end_position;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: numerator of the normalized time and the half-period test.
  // ---------------------------------------------------------------------------
  logic signed [WW-1:0]        t1;
  logic signed [WW-1:0]        num2_r, num2_nxt;
  logic                        first2_r, first2_nxt;
  logic [TW-1:0]               el2_r;
  logic signed [PMP_POS_W-1:0] st2_r, en2_r;

  assign t1         = $signed({2'b00, el1_r, 17'd0});
  assign num2_nxt   = t1 - d_w;
  assign first2_nxt = {el1_r, 1'b0} < {1'b0, cfg_period};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      num2_r   <= num2_nxt;
      first2_r <= first2_nxt;
      el2_r    <= el1_r;
      st2_r    <= st1_r;
      en2_r    <= en1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3 (divider entry): dead-time tests and choice of the fraction source.
  // Then one restoring quotient bit per stage.
  // ---------------------------------------------------------------------------
  div_stage_t            div_r   [FB+1];
  div_stage_t            div_nxt [FB+1];
  logic signed [WW-1:0]  t2;
  logic                  span_le0, num_le0;

  assign t2       = $signed({2'b00, el2_r, 17'd0});
  assign span_le0 = span_cfg_r[WW-1] || (span_cfg_r == '0);
  assign num_le0  = num2_r[WW-1] || (num2_r == '0);

  always_comb begin
    div_nxt[0].rem   = num2_r[RW-1:0];
    div_nxt[0].quo   = '0;
    div_nxt[0].lo    = t2 < dh_cfg_r;
    div_nxt[0].hi    = t2 > pdh_cfg_r;
    div_nxt[0].first = first2_r;
    div_nxt[0].st    = st2_r;
    div_nxt[0].en    = en2_r;
    if (span_le0 || (num2_r >= span_cfg_r)) begin
      div_nxt[0].fsel = FSEL_ONE;
    end else if (num_le0) begin
      div_nxt[0].fsel = FSEL_ZERO;
    end else begin
      div_nxt[0].fsel = FSEL_DIV;
    end
  end

  for (genvar k = 1; k <= FB; k++) begin : g_div
    logic [RW-1:0] rem2;
    logic          ge;

    // Shift the remainder, try the subtraction, record the quotient bit.
    assign rem2 = {div_r[k-1].rem[RW-2:0], 1'b0};
    assign ge   = rem2 >= span_u;

    always_comb begin
      div_nxt[k]     = div_r[k-1];
      div_nxt[k].rem = ge ? (rem2 - span_u) : rem2;
      div_nxt[k].quo = {div_r[k-1].quo[FB-2:0], ge};
    end
  end

  for (genvar k = 0; k <= FB; k++) begin : g_div_reg
    logic vprev;

    if (k == 0) begin : g_first
      assign vprev = v2_r;
    end else begin : g_rest
      assign vprev = dv_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (dadv[k]) begin
        dv_r[k] <= vprev;
      end
    end

    always_ff @(posedge clk) begin
      if (dadv[k]) begin
        div_r[k] <= div_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Fraction stage: final fraction and its square.
  // ---------------------------------------------------------------------------
  logic [FW-1:0]               f_nxt, f_r, f2_r;
  logic [SQW-1:0]              sq;
  logic                        lof_r, hif_r, firstf_r;
  logic signed [PMP_POS_W-1:0] stf_r, enf_r;

  always_comb begin
    case (div_r[FB].fsel)
      FSEL_ONE:  f_nxt = F_ONE;
      FSEL_ZERO: f_nxt = '0;
      FSEL_DIV:  f_nxt = {1'b0, div_r[FB].quo};
      default:   f_nxt = '0;
    endcase
  end

  assign sq = SQW'(f_nxt) * SQW'(f_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (advf) begin
      vf_r <= dv_r[FB];
    end
  end

  always_ff @(posedge clk) begin
    if (advf) begin
      f_r      <= f_nxt;
      f2_r     <= sq[FB +: FW];
      lof_r    <= div_r[FB].lo;
      hif_r    <= div_r[FB].hi;
      firstf_r <= div_r[FB].first;
      stf_r    <= div_r[FB].st;
      enf_r    <= div_r[FB].en;
    end
  end

  // ---------------------------------------------------------------------------
  // Profile stage: flat ends, accelerating or decelerating parabola.
  // ---------------------------------------------------------------------------
  logic signed [YW-1:0]        fx, f2x, y_nxt, y_r;
  logic signed [DFW-1:0]       diff_r;
  logic signed [PMP_POS_W-1:0] sty_r;

  assign fx  = $signed({3'b000, f_r});
  assign f2x = $signed({3'b000, f2_r});

  always_comb begin
    if (lof_r) begin
      y_nxt = '0;
    end else if (hif_r) begin
      y_nxt = Y_ONE;
    end else if (firstf_r) begin
      y_nxt = f2x <<< 1;
    end else begin
      y_nxt = (fx <<< 2) - (f2x <<< 1) - Y_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vy_r <= 1'b0;
    end else if (advy) begin
      vy_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advy) begin
      y_r    <= y_nxt;
      diff_r <= $signed({enf_r[PMP_POS_W-1], enf_r}) - $signed({stf_r[PMP_POS_W-1], stf_r});
      sty_r  <= stf_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Scale stage: endpoint difference times the profile value.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]        prod_r;
  logic signed [PMP_POS_W-1:0] stm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (advm) begin
      vm_r <= vy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advm) begin
      prod_r <= PW'(diff_r) * PW'(y_r);
      stm_r  <= sty_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: floor shift, add the start position and saturate.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]        sum;
  logic                        over, under;
  logic [PMP_POS_W-1:0]        pos_nxt;
  logic signed [PMP_POS_W-1:0] out_pos_r;
  logic                        out_sat_r;

  assign sum   = PW'(stm_r) + (prod_r >>> FB);
  assign over  = !sum[PW-1] && (|sum[PW-2:PMP_POS_W-1]);
  assign under = sum[PW-1] && !(&sum[PW-2:PMP_POS_W-1]);

  always_comb begin
    if (over) begin
      pos_nxt = PMP_POS_MAX;
    end else if (under) begin
      pos_nxt = PMP_POS_MIN;
    end else begin
      pos_nxt = sum[PMP_POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advo) begin
      out_valid_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advo) begin
      out_pos_r <= $signed(pos_nxt);
      out_sat_r <= over || under;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.position  = out_pos_r;
  assign out_ch.saturated = out_sat_r;

endmodule

// File: sv/parabolic_motion_profile.sv
// Top level of the parabolic motion profile: configuration registers on an APB-style
// port and the pipelined core. Depends on pmp_pkg, pmp_in_if, pmp_out_if, pmp_core.
//
// Usage:
//   in_ch carries one time sample per word (elapsed time, start and end position);
//   out_ch returns one word per sample (saturated position and a clip flag), in order.
//   Both channels move a word when valid and ready are high at a clock edge.
//   Registers: tick_length at 0x0, cycle_period at 0x4, dead_fraction at 0x8; write
//   them only while no sample is in flight. pready is always high.
// Pipeline: input capture, numerator, normalized-time divider, fraction, profile,
//   scale and output; the divider takes one quotient bit per stage and sets the depth.
// Throughput: one sample in and one word out per cycle while out_ch.ready is high.
// Reset (rst_n low, synchronous): registers return to tick 10000, period 1000000,
//   dead fraction 0, and the pipeline empties; the block is ready on the next cycle.
// Stall: when out_ch.ready is low the result is held; earlier stages keep filling
//   any empty slots and in_ch.ready drops only when every stage holds a word.
module parabolic_motion_profile import pmp_pkg::*; #(
  parameter int TIME_WIDTH    = PMP_TIME_WIDTH,
  parameter int FRACTION_BITS = PMP_FRACTION_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pmp_in_if.sink                in_ch,
  pmp_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [PMP_ADDR_W-1:0] cfg_paddr,
  input  logic [PMP_DATA_W-1:0] cfg_pwdata,
  output logic [PMP_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [PMP_CFG_TW-1:0]   tick_length_r;
  logic [PMP_CFG_TW-1:0]   cycle_period_r;
  logic [PMP_DEAD_W-1:0]   dead_fraction_r;
  logic [PMP_REG_IDXW-1:0] reg_idx;
  logic                    wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[PMP_ADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes in the access cycle; unmapped addresses are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_length_r   <= PMP_TICK_RESET;
      cycle_period_r  <= PMP_PERIOD_RESET;
      dead_fraction_r <= PMP_DEAD_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TICK:   tick_length_r   <= cfg_pwdata[PMP_CFG_TW-1:0];
        REG_PERIOD: cycle_period_r  <= cfg_pwdata[PMP_CFG_TW-1:0];
        REG_DEAD:   dead_fraction_r <= cfg_pwdata[PMP_DEAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_TICK:   cfg_prdata = PMP_DATA_W'(tick_length_r);
      REG_PERIOD: cfg_prdata = PMP_DATA_W'(cycle_period_r);
      REG_DEAD:   cfg_prdata = PMP_DATA_W'(dead_fraction_r);
      default:    cfg_prdata = '0;
    endcase
  end

  pmp_core #(
    .TIME_WIDTH    (TIME_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_period (TIME_WIDTH'(cycle_period_r)),
    .cfg_tick   (TIME_WIDTH'(tick_length_r)),
    .cfg_dead   (dead_fraction_r),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

endmodule
